### src/btp_pkg.sv
// Package for the bencode token parser: transaction structs, token kinds,
// error codes and the ASCII characters of the grammar. No dependencies.
`default_nettype none

package btp_pkg;

  // Token kinds.
  localparam logic [2:0] KIND_STR_START = 3'd0;
  localparam logic [2:0] KIND_STR_BYTE  = 3'd1;
  localparam logic [2:0] KIND_INT       = 3'd2;
  localparam logic [2:0] KIND_LIST      = 3'd3;
  localparam logic [2:0] KIND_MAP       = 3'd4;
  localparam logic [2:0] KIND_CLOSE     = 3'd5;
  localparam logic [2:0] KIND_ERROR     = 3'd6;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_BAD_INT    = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd3;
  localparam logic [2:0] ERR_NESTING    = 3'd4;
  localparam logic [2:0] ERR_KEY        = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd6;
  localparam logic [2:0] ERR_TRAILING   = 3'd7;

  // Characters of the grammar.
  localparam logic [7:0] CH_INT   = 8'h69;  // i
  localparam logic [7:0] CH_END   = 8'h65;  // e
  localparam logic [7:0] CH_LIST  = 8'h6C;  // l
  localparam logic [7:0] CH_MAP   = 8'h64;  // d
  localparam logic [7:0] CH_COLON = 8'h3A;  // :
  localparam logic [7:0] CH_MINUS = 8'h2D;  // -
  localparam logic [7:0] CH_ZERO  = 8'h30;  // 0
  localparam logic [7:0] CH_NINE  = 8'h39;  // 9

  // One input transaction.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_value;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]         token_kind;
    logic signed [63:0] number_out;
    logic [7:0]         payload_byte;
    logic               is_map_key;
    logic               value_done;
    logic [2:0]         error_code;
  } token_t;

endpackage

`default_nettype wire

### src/btp_in_stage.sv
// Input register of the bencode token parser.
// Depends on btp_pkg for the input transaction struct.
`default_nettype none

module btp_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire btp_pkg::in_item_t in_data_i,
  input  wire logic              advance_i,
  output logic                   item_vld_o,
  output btp_pkg::in_item_t      item_o
);

  logic              vld_q, vld_d;
  btp_pkg::in_item_t item_q;
  logic              accept;

  // The register is refilled in the same cycle it hands its byte onward.
  assign in_stall_o = vld_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

`default_nettype wire

### src/btp_core.sv
// Parse state and per-byte step logic of the bencode token parser.
// Depends on btp_pkg for the structs, token kinds, error codes and characters.
`default_nettype none

module btp_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire btp_pkg::in_item_t item_i,
  output logic                   tok_vld_o,
  output btp_pkg::token_t        tok_o
);

  // Parse modes.
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_INT   = 3'd1;
  localparam logic [2:0] MODE_LEN   = 3'd2;
  localparam logic [2:0] MODE_STR   = 3'd3;
  localparam logic [2:0] MODE_DONE  = 3'd4;
  localparam logic [2:0] MODE_SKIP  = 3'd5;

  // Container types.
  localparam logic [1:0] CT_NONE = 2'd0;
  localparam logic [1:0] CT_LIST = 2'd1;
  localparam logic [1:0] CT_MAP  = 2'd2;

  logic [2:0]             mode_q, mode_d;
  logic [1:0]             ct_q, ct_d;
  logic                   key_q, key_d;
  logic [63:0]            acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic                   dig_q, dig_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic                   vc_q, vc_d;

  logic [7:0]             byte_in;
  logic                   last;
  logic                   map_key;
  logic                   is_dig;
  logic [3:0]             digit;
  logic [67:0]            acc_wide;
  logic [67:0]            acc_x10;
  logic [67:0]            int_lim;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   item_end;
  logic                   done;
  logic                   have;
  logic [2:0]             err;
  btp_pkg::token_t        tok;

  assign byte_in  = item_i.in_byte;
  assign last     = item_i.end_of_value;
  assign map_key  = (ct_q == CT_MAP) && key_q;
  assign is_dig   = byte_in inside {[btp_pkg::CH_ZERO:btp_pkg::CH_NINE]};
  assign digit    = byte_in[3:0];

  // Next accumulator value, times ten by shift and add, kept wide for the
  // range checks.
  assign acc_wide = {4'd0, acc_q};
  assign acc_x10  = (acc_wide << 3) + (acc_wide << 1) + {64'd0, digit};
  // Largest magnitude: 2^63 for a negative integer, 2^63 - 1 otherwise.
  assign int_lim  = {4'd0, neg_q, {63{~neg_q}}};
  assign rem_dec  = rem_q - {{(LENGTH_BITS-1){1'b0}}, (rem_q != '0)};

  // One byte of the grammar.
  always_comb begin
    mode_d   = mode_q;
    ct_d     = ct_q;
    key_d    = key_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    dig_d    = dig_q;
    rem_d    = rem_q;
    vc_d     = vc_q;
    item_end = 1'b0;
    done     = 1'b0;
    have     = 1'b0;
    err      = btp_pkg::ERR_NONE;
    tok      = '0;

    case (mode_q)
      MODE_START: begin
        if (byte_in == btp_pkg::CH_END && (ct_q == CT_LIST || map_key)) begin
          tok.token_kind = btp_pkg::KIND_CLOSE;
          have   = 1'b1;
          ct_d   = CT_NONE;
          key_d  = 1'b0;
          vc_d   = 1'b1;
          mode_d = MODE_DONE;
          done   = 1'b1;
        end else if (is_dig) begin
          acc_d  = {60'd0, digit};
          mode_d = MODE_LEN;
        end else if (map_key) begin
          err = btp_pkg::ERR_KEY;
        end else if (byte_in == btp_pkg::CH_INT) begin
          acc_d  = '0;
          neg_d  = 1'b0;
          dig_d  = 1'b0;
          mode_d = MODE_INT;
        end else if (byte_in == btp_pkg::CH_LIST || byte_in == btp_pkg::CH_MAP) begin
          if (ct_q != CT_NONE) begin
            err = btp_pkg::ERR_NESTING;
          end else if (byte_in == btp_pkg::CH_LIST) begin
            tok.token_kind = btp_pkg::KIND_LIST;
            have = 1'b1;
            ct_d = CT_LIST;
          end else begin
            tok.token_kind = btp_pkg::KIND_MAP;
            have  = 1'b1;
            ct_d  = CT_MAP;
            key_d = 1'b1;
          end
        end else begin
          err = btp_pkg::ERR_UNEXPECTED;
        end
      end
      MODE_INT: begin
        if (byte_in == btp_pkg::CH_END) begin
          if (!dig_q) begin
            err = btp_pkg::ERR_BAD_INT;
          end else begin
            tok.token_kind = btp_pkg::KIND_INT;
            tok.number_out = neg_q ? -$signed(acc_q) : $signed(acc_q);
            have     = 1'b1;
            acc_d    = '0;
            neg_d    = 1'b0;
            dig_d    = 1'b0;
            item_end = 1'b1;
          end
        end else if (byte_in == btp_pkg::CH_MINUS) begin
          if (dig_q || neg_q) begin
            err = btp_pkg::ERR_BAD_INT;
          end else begin
            neg_d = 1'b1;
          end
        end else if (is_dig) begin
          if (dig_q && acc_q == '0) begin
            err = btp_pkg::ERR_BAD_INT;
          end else if (!dig_q && neg_q && digit == 4'd0) begin
            err = btp_pkg::ERR_BAD_INT;
          end else if (acc_x10 > int_lim) begin
            err = btp_pkg::ERR_OVERFLOW;
          end else begin
            acc_d = acc_x10[63:0];
            dig_d = 1'b1;
          end
        end else begin
          err = btp_pkg::ERR_BAD_INT;
        end
      end
      MODE_LEN: begin
        if (is_dig) begin
          if (acc_x10[67:LENGTH_BITS] != '0) begin
            err = btp_pkg::ERR_OVERFLOW;
          end else begin
            acc_d = acc_x10[63:0];
          end
        end else if (byte_in == btp_pkg::CH_COLON) begin
          tok.token_kind = btp_pkg::KIND_STR_START;
          tok.number_out = $signed(acc_q);
          tok.is_map_key = map_key;
          have  = 1'b1;
          rem_d = acc_q[LENGTH_BITS-1:0];
          acc_d = '0;
          if (acc_q == '0) begin
            item_end = 1'b1;
          end else begin
            mode_d = MODE_STR;
          end
        end else begin
          err = btp_pkg::ERR_BAD_INT;
        end
      end
      MODE_STR: begin
        tok.token_kind   = btp_pkg::KIND_STR_BYTE;
        tok.payload_byte = byte_in;
        tok.is_map_key   = map_key;
        have  = 1'b1;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          item_end = 1'b1;
        end
      end
      MODE_DONE: begin
        err = btp_pkg::ERR_TRAILING;
      end
      default: begin
      end
    endcase

    // A string or integer has ended: finish the value or step the container.
    if (item_end) begin
      if (ct_q == CT_NONE) begin
        vc_d   = 1'b1;
        mode_d = MODE_DONE;
        done   = 1'b1;
      end else begin
        if (ct_q == CT_MAP) begin
          key_d = ~key_q;
        end
        mode_d = MODE_START;
      end
    end

    // Skipping after an error drops bytes; otherwise check for truncation.
    if (mode_q == MODE_SKIP) begin
      have = 1'b0;
    end else begin
      if (err == btp_pkg::ERR_NONE && last && !vc_d) begin
        err = btp_pkg::ERR_TRUNCATED;
      end
      if (err != btp_pkg::ERR_NONE) begin
        tok            = '0;
        tok.token_kind = btp_pkg::KIND_ERROR;
        tok.error_code = err;
        done   = 1'b1;
        have   = 1'b1;
        mode_d = MODE_SKIP;
      end
    end
    tok.value_done = done;

    // The final byte of a value always returns the parser to its idle state.
    if (last) begin
      mode_d = MODE_START;
      ct_d   = CT_NONE;
      key_d  = 1'b0;
      acc_d  = '0;
      neg_d  = 1'b0;
      dig_d  = 1'b0;
      rem_d  = '0;
      vc_d   = 1'b0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      ct_q   <= CT_NONE;
      key_q  <= 1'b0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      dig_q  <= 1'b0;
      rem_q  <= '0;
      vc_q   <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      ct_q   <= ct_d;
      key_q  <= key_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      dig_q  <= dig_d;
      rem_q  <= rem_d;
      vc_q   <= vc_d;
    end
  end

  assign tok_vld_o = have;
  assign tok_o     = tok;

endmodule

`default_nettype wire

### src/btp_out_stage.sv
// Result register of the bencode token parser.
// Depends on btp_pkg for the token struct.
`default_nettype none

module btp_out_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire btp_pkg::token_t tok_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output btp_pkg::token_t      out_data_o
);

  logic            vld_q, vld_d;
  btp_pkg::token_t tok_q;

  // The register can take a new token when empty or when its token leaves.
  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (free_o) begin
      vld_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      tok_q <= tok_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = tok_q;

endmodule

`default_nettype wire

### src/bencode_token_parser.sv
// Bencode token parser: one bencoded value in, one byte per transaction, and
// at most one token out per byte. A byte is registered on acceptance,
// parsed once the result register can take its token, and its token is
// registered there; one byte per cycle while out_stall_i stays low.
// Reset clears the parse state and both valid flags; payload is not reset.
// Depends on btp_pkg, btp_in_stage, btp_core and btp_out_stage.
`default_nettype none

module bencode_token_parser #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire btp_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output btp_pkg::token_t        out_data_o
);

  logic              item_vld;
  btp_pkg::in_item_t item;
  logic              out_free;
  logic              advance;
  logic              tok_vld;
  btp_pkg::token_t   tok;

  // A registered byte is parsed once the result register can take its token.
  assign advance = item_vld && out_free;

  btp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  btp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (item),
    .tok_vld_o (tok_vld),
    .tok_o     (tok)
  );

  btp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && tok_vld),
    .tok_i       (tok),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
